[src/assert_macros.svh]
// Assertion macros used by the top level of the heartbeat supervisor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PHS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

`define PHS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define PHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define PHS_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define PHS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PHS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/phs_pkg.sv]
// Types, constants and helpers of the peer heartbeat supervisor.
package phs_pkg;

	localparam int MAX_PEERS   = 16;
	localparam int RES_SLOTS   = 16;
	localparam int CNT_W       = $clog2(MAX_PEERS + 1);
	localparam int LOSS_W      = $clog2(RES_SLOTS + 1);
	localparam int ALIVE_OUT_W = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [ALIVE_OUT_W-1:0] ALIVE_MAX = 5'd31;

	localparam logic REQ_HEARTBEAT = 1'b0;
	localparam logic REQ_POLL      = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BCAST   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ID  = 2'd2;

	typedef enum logic [1:0] {
		STAT_UNKNOWN = 2'd0,
		STAT_ALIVE   = 2'd1,
		STAT_LOST    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_JOINED   = 2'd1,
		EV_REBOOTED = 2'd2,
		EV_LOST     = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HB_SCAN,
		ST_POLL_COUNT,
		ST_POLL_EMIT,
		ST_RESULT
	} phs_state_t;

	typedef struct packed {
		logic [7:0]  node;
		status_t     status;
		logic [31:0] uptime;
		logic [31:0] seen;
		logic [31:0] hbs;
	} entry_t;

	typedef struct packed {
		logic [31:0] lost_after_ms;
		logic [7:0]  broadcast_node_id;
		logic [7:0]  max_node_id;
	} cfg_t;

	typedef struct packed {
		event_t                 event_res;
		logic                   accepted;
		logic [7:0]             peer_id;
		logic [31:0]            peer_uptime;
		logic [31:0]            peer_heartbeats;
		logic [ALIVE_OUT_W-1:0] alive_count;
		logic                   last;
	} res_t;

	typedef struct packed {
		phs_state_t       state;
		logic [CNT_W-1:0] peer_count;
		logic [CNT_W-1:0] alive;
	} mon_t;

	function automatic logic [ALIVE_OUT_W-1:0] sat_alive(input logic [CNT_W-1:0] n);
		if (int'(n) > int'(ALIVE_MAX)) begin
			return ALIVE_MAX;
		end
		return ALIVE_OUT_W'(n);
	endfunction

endpackage

[src/phs_req_if.sv]
// Request channel: heartbeat or poll requests into the supervisor.
interface phs_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [7:0]  node_id;
	logic [31:0] heartbeat_uptime;
	logic [31:0] now_ms;

	modport source (output valid, req_type, node_id, heartbeat_uptime, now_ms, input ready);
	modport sink (input valid, req_type, node_id, heartbeat_uptime, now_ms, output ready);
endinterface

[src/phs_res_if.sv]
// Result channel: peer events out of the supervisor.
interface phs_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_res;
	logic        accepted;
	logic [7:0]  peer_id;
	logic [31:0] peer_uptime;
	logic [31:0] peer_heartbeats;
	logic [4:0]  alive_count;
	logic        last;

	modport source (output valid, event_res, accepted, peer_id, peer_uptime,
		peer_heartbeats, alive_count, last, input ready);
	modport sink (input valid, event_res, accepted, peer_id, peer_uptime,
		peer_heartbeats, alive_count, last, output ready);
endinterface

[src/phs_cell.sv]
// One storage cell of the rotating peer table.
module phs_cell import phs_pkg::*; (
	input  logic   clk,
	input  logic   shift,
	input  entry_t d,
	output entry_t q
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

[src/phs_ctrl.sv]
// Sequencer and head cell logic: scans the rotating table and builds results.
module phs_ctrl import phs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	phs_req_if.sink    req,
	phs_res_if.source  res,
	input  entry_t     head_q,
	output entry_t     head_d,
	output logic       shift,
	output mon_t       mon
);

	phs_state_t       state_q, state_d;
	logic [CNT_W-1:0] step_q, step_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] alive_q, alive_d;
	logic             found_q, found_d;
	logic [LOSS_W-1:0] total_q, total_d;
	logic [LOSS_W-1:0] sent_q, sent_d;
	logic             out_valid_q, out_valid_d;

	logic             poll_q, poll_d;
	logic             bad_q, bad_d;
	logic [7:0]       node_q, node_d;
	logic [31:0]      up_q, up_d;
	logic [31:0]      now_q, now_d;
	event_t           ev_q, ev_d;
	logic [31:0]      hbs_q, hbs_d;
	res_t             out_q, res_d;

	logic             load;
	logic             head_valid;
	logic             pass_end;
	logic             hb_hit;
	logic             hb_new;
	logic             expired;
	logic             loss;
	logic             out_free;
	logic [31:0]      elapsed;
	logic [31:0]      hbs_next;

	assign head_valid = step_q < count_q;
	assign pass_end   = step_q == CNT_W'(MAX_PEERS - 1);
	assign hb_hit     = head_valid && (head_q.node == node_q) && !found_q && !bad_q;
	// The first empty slot passes the head once all stored peers have been seen.
	assign hb_new     = (step_q == count_q) && !found_q && !bad_q;
	assign elapsed    = now_q - head_q.seen;
	assign expired    = head_valid && (head_q.status == STAT_ALIVE) &&
		(elapsed > cfg.lost_after_ms);
	assign loss       = expired && (sent_q < total_q);
	assign out_free   = !out_valid_q || res.ready;
	assign hbs_next   = (hb_new ? 32'd0 : head_q.hbs) + 32'd1;

	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		count_d     = count_q;
		alive_d     = alive_q;
		found_d     = found_q;
		total_d     = total_q;
		sent_d      = sent_q;
		poll_d      = poll_q;
		bad_d       = bad_q;
		node_d      = node_q;
		up_d        = up_q;
		now_d       = now_q;
		ev_d        = ev_q;
		hbs_d       = hbs_q;
		head_d      = head_q;
		shift       = 1'b0;
		load        = 1'b0;
		res_d       = out_q;
		req.ready   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					poll_d  = req.req_type == REQ_POLL;
					node_d  = req.node_id;
					up_d    = req.heartbeat_uptime;
					now_d   = req.now_ms;
					bad_d   = (req.node_id == cfg.broadcast_node_id) ||
						(req.node_id > cfg.max_node_id);
					found_d = 1'b0;
					step_d  = '0;
					total_d = '0;
					sent_d  = '0;
					state_d = (req.req_type == REQ_POLL) ? ST_POLL_COUNT : ST_HB_SCAN;
				end
			end

			ST_HB_SCAN: begin
				shift  = 1'b1;
				step_d = step_q + CNT_W'(1);
				if (hb_hit || hb_new) begin
					head_d.node   = node_q;
					head_d.status = STAT_ALIVE;
					head_d.uptime = up_q;
					head_d.seen   = now_q;
					head_d.hbs    = hbs_next;
					found_d       = 1'b1;
					hbs_d         = hbs_next;
					if (hb_new || head_q.status != STAT_ALIVE) begin
						ev_d    = EV_JOINED;
						alive_d = alive_q + CNT_W'(1);
					end else if (up_q < head_q.uptime) begin
						ev_d = EV_REBOOTED;
					end else begin
						ev_d = EV_NONE;
					end
					if (hb_new) begin
						count_d = count_q + CNT_W'(1);
					end
				end
				if (pass_end) begin
					step_d  = '0;
					state_d = ST_RESULT;
				end
			end

			ST_POLL_COUNT: begin
				shift  = 1'b1;
				step_d = step_q + CNT_W'(1);
				if (expired && (total_q < LOSS_W'(RES_SLOTS))) begin
					total_d = total_q + LOSS_W'(1);
				end
				if (pass_end) begin
					step_d = '0;
					if (total_d == '0) begin
						state_d = ST_RESULT;
					end else begin
						// Every result of the poll carries the count after all losses.
						alive_d = alive_q - CNT_W'(total_d);
						state_d = ST_POLL_EMIT;
					end
				end
			end

			ST_POLL_EMIT: begin
				// The ring holds still while a loss waits for the output register.
				if (!loss || out_free) begin
					shift  = 1'b1;
					step_d = step_q + CNT_W'(1);
					if (loss) begin
						head_d.status         = STAT_LOST;
						load                  = 1'b1;
						res_d.event_res       = EV_LOST;
						res_d.accepted        = 1'b1;
						res_d.peer_id         = head_q.node;
						res_d.peer_uptime     = head_q.uptime;
						res_d.peer_heartbeats = head_q.hbs;
						res_d.alive_count     = sat_alive(alive_q);
						res_d.last            = LOSS_W'(sent_q + LOSS_W'(1)) == total_q;
						sent_d                = sent_q + LOSS_W'(1);
					end
					if (pass_end) begin
						step_d  = '0;
						state_d = ST_IDLE;
					end
				end
			end

			ST_RESULT: begin
				if (out_free) begin
					load              = 1'b1;
					res_d.alive_count = sat_alive(alive_q);
					res_d.last        = 1'b1;
					if (poll_q) begin
						res_d.event_res       = EV_NONE;
						res_d.accepted        = 1'b1;
						res_d.peer_id         = 8'd0;
						res_d.peer_uptime     = 32'd0;
						res_d.peer_heartbeats = 32'd0;
					end else if (found_q) begin
						res_d.event_res       = ev_q;
						res_d.accepted        = 1'b1;
						res_d.peer_id         = node_q;
						res_d.peer_uptime     = up_q;
						res_d.peer_heartbeats = hbs_q;
					end else begin
						res_d.event_res       = EV_NONE;
						res_d.accepted        = 1'b0;
						res_d.peer_id         = node_q;
						res_d.peer_uptime     = 32'd0;
						res_d.peer_heartbeats = 32'd0;
					end
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (load) begin
			out_valid_d = 1'b1;
		end else if (res.ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			count_q     <= '0;
			alive_q     <= '0;
			found_q     <= 1'b0;
			total_q     <= '0;
			sent_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			count_q     <= count_d;
			alive_q     <= alive_d;
			found_q     <= found_d;
			total_q     <= total_d;
			sent_q      <= sent_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		poll_q <= poll_d;
		bad_q  <= bad_d;
		node_q <= node_d;
		up_q   <= up_d;
		now_q  <= now_d;
		ev_q   <= ev_d;
		hbs_q  <= hbs_d;
		if (load) begin
			out_q <= res_d;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.event_res       = out_q.event_res;
	assign res.accepted        = out_q.accepted;
	assign res.peer_id         = out_q.peer_id;
	assign res.peer_uptime     = out_q.peer_uptime;
	assign res.peer_heartbeats = out_q.peer_heartbeats;
	assign res.alive_count     = out_q.alive_count;
	assign res.last            = out_q.last;

	assign mon.state      = state_q;
	assign mon.peer_count = count_q;
	assign mon.alive      = alive_q;

endmodule

[src/peer_heartbeat_supervisor_top.sv]
// Top level of the peer heartbeat supervisor: configuration, peer table ring, sequencer.
//
// Requests arrive on req (valid/ready): req_type 0 is a heartbeat from node_id with its
// uptime, req_type 1 is a poll for timed-out peers; now_ms is the current time for both.
// Results leave on res (valid/ready); the final result of a request has last set.
// The peer table is a ring of MAX_PEERS cells that rotates past one head cell, one
// entry per cycle while no poll holds it for a stalled receiver, so every request
// costs whole rotations of the ring. A heartbeat takes one rotation and gives a single
// result. A poll takes a counting rotation and, when peers were lost, an emitting
// rotation. A poll without losses behaves like a heartbeat.
// req.ready is high again once the final rotation of a request has ended and its last
// result has been loaded into the output register, so a new request is taken only
// after the previous one has finished.
// A stalled receiver holds the output register; a poll then halts its ring until the
// pending loss can be handed over. No result is dropped.
// Reset clears the peer count and the sequencer and restores the register defaults;
// table entries carry no reset and are only read once written.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written by the user while no
// request is in flight; the block itself does not enforce this.
`include "assert_macros.svh"

module peer_heartbeat_supervisor_top import phs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	phs_req_if.sink               req,
	phs_res_if.source             res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t   cfg_q;
	entry_t cell_q [MAX_PEERS];
	entry_t head_d;
	logic   shift;
	mon_t   mon;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lost_after_ms     <= 32'd1000;
			cfg_q.broadcast_node_id <= 8'd0;
			cfg_q.max_node_id       <= 8'd127;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIMEOUT: cfg_q.lost_after_ms     <= cfg_data;
				CFG_BCAST:   cfg_q.broadcast_node_id <= cfg_data[7:0];
				CFG_MAX_ID:  cfg_q.max_node_id       <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	for (genvar i = 0; i < MAX_PEERS; i++) begin : g_ring
		if (i == MAX_PEERS - 1) begin : g_tail
			phs_cell u_cell (
				.clk   (clk),
				.shift (shift),
				.d     (head_d),
				.q     (cell_q[i])
			);
		end else begin : g_mid
			phs_cell u_cell (
				.clk   (clk),
				.shift (shift),
				.d     (cell_q[i+1]),
				.q     (cell_q[i])
			);
		end
	end

	phs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (req),
		.res    (res),
		.head_q (cell_q[0]),
		.head_d (head_d),
		.shift  (shift),
		.mon    (mon)
	);

	`PHS_ASSERT_ALWAYS(a_alive_in_table, clk, arst_n, mon.alive <= mon.peer_count)
	`PHS_ASSERT_ALWAYS(a_count_bound, clk, arst_n, mon.peer_count <= CNT_W'(MAX_PEERS))
	`PHS_ASSERT_ALWAYS(a_count_grows, clk, arst_n, mon.peer_count >= $past(mon.peer_count))
	`PHS_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req.valid && req.ready, !req.ready)
	`PHS_ASSERT_IMPLIES(a_ready_when_idle, clk, arst_n, req.ready, mon.state == ST_IDLE)

endmodule

[verif/tb_peer_heartbeat_supervisor_top.sv]
// Self-checking testbench of the peer heartbeat supervisor: directed table, then random phases.
module tb_peer_heartbeat_supervisor_top;
	import phs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int PHASES = 5;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic        rt;
		logic [7:0]  node;
		logic [31:0] up;
		logic [31:0] now;
		bit          typed;
		event_t      ev;
		logic        acc;
		logic [7:0]  id;
		logic [31:0] pup;
		logic [31:0] phb;
		logic [4:0]  alive;
	} probe_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	phs_req_if req_ch ();
	phs_res_if res_ch ();

	peer_heartbeat_supervisor_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the block's peer table and registers.
	entry_t peers [MAX_PEERS];
	int     n_peers;
	cfg_t   limits;
	res_t   pending_events [$];
	res_t   step_events [$];
	int     mismatches = 0;

	// Rows with typed-in results can be read straight off the behavior; the rest go
	// through the table mirror.
	probe_t probes [26] = '{
		'{REQ_POLL, 8'd0, 32'd0, 32'd0, 1'b1, EV_NONE, 1'b1, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd255, 32'd1, 32'd0, 1'b1, EV_NONE, 1'b0, 8'd255, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd127, 32'hFFFF_FFFF, 32'd0, 1'b1, EV_JOINED, 1'b1, 8'd127,
			32'hFFFF_FFFF, 32'd1, 5'd1},
		'{REQ_HEARTBEAT, 8'd1, 32'd0, 32'd0, 1'b1, EV_JOINED, 1'b1, 8'd1, 32'd0, 32'd1, 5'd2},
		'{REQ_HEARTBEAT, 8'd127, 32'd5, 32'd10, 1'b1, EV_REBOOTED, 1'b1, 8'd127, 32'd5, 32'd2,
			5'd2},
		'{REQ_HEARTBEAT, 8'd1, 32'd0, 32'd20, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_POLL, 8'hAA, 32'h5555_5555, 32'd1010, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_POLL, 8'd0, 32'd0, 32'd1011, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd127, 32'd3, 32'd1020, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd2, 32'h1111_1111, 32'd1030, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd3, 32'h2222_2222, 32'd1030, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd4, 32'h3333_3333, 32'd1030, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd5, 32'h4444_4444, 32'd1030, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd6, 32'h5555_5555, 32'd1030, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd7, 32'h6666_6666, 32'd1030, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd8, 32'h7777_7777, 32'd1030, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd9, 32'h8888_8888, 32'd1030, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd10, 32'h9999_9999, 32'd1030, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd11, 32'hAAAA_AAAA, 32'd1030, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd12, 32'hBBBB_BBBB, 32'd1030, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd13, 32'hCCCC_CCCC, 32'd1030, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd14, 32'hDDDD_DDDD, 32'd1030, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd15, 32'hEEEE_EEEE, 32'd1030, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_HEARTBEAT, 8'd16, 32'd7, 32'd1030, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0},
		'{REQ_POLL, 8'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, EV_NONE, 1'b0, 8'd0, 32'd0, 32'd0, 5'd0}
	};

	// Applies one request to the table mirror and leaves its results in step_events.
	function automatic void track_peers(input logic rt, input logic [7:0] node,
		input logic [31:0] up, input logic [31:0] now);
		int slot;
		int alive;
		res_t r;
		logic [31:0] elapsed;
		step_events.delete();
		r = '0;
		if (rt == REQ_HEARTBEAT) begin
			slot = -1;
			for (int i = 0; i < n_peers; i++) begin
				if (slot < 0 && peers[i].node == node) begin
					slot = i;
				end
			end
			r.peer_id = node;
			if (node == limits.broadcast_node_id || node > limits.max_node_id ||
				(slot < 0 && n_peers >= MAX_PEERS)) begin
				r.accepted = 1'b0;
			end else begin
				if (slot < 0) begin
					slot = n_peers;
					n_peers++;
					peers[slot] = '0;
					peers[slot].node = node;
				end
				if (peers[slot].status != STAT_ALIVE) begin
					r.event_res = EV_JOINED;
				end else if (up < peers[slot].uptime) begin
					r.event_res = EV_REBOOTED;
				end else begin
					r.event_res = EV_NONE;
				end
				peers[slot].uptime = up;
				peers[slot].seen = now;
				peers[slot].status = STAT_ALIVE;
				peers[slot].hbs = peers[slot].hbs + 32'd1;
				r.accepted = 1'b1;
				r.peer_uptime = up;
				r.peer_heartbeats = peers[slot].hbs;
			end
			step_events.push_back(r);
		end else begin
			for (int i = 0; i < n_peers && step_events.size() < RES_SLOTS; i++) begin
				elapsed = now - peers[i].seen;
				if (peers[i].status == STAT_ALIVE && elapsed > limits.lost_after_ms) begin
					peers[i].status = STAT_LOST;
					r = '0;
					r.event_res = EV_LOST;
					r.accepted = 1'b1;
					r.peer_id = peers[i].node;
					r.peer_uptime = peers[i].uptime;
					r.peer_heartbeats = peers[i].hbs;
					step_events.push_back(r);
				end
			end
			if (step_events.size() == 0) begin
				r = '0;
				r.accepted = 1'b1;
				step_events.push_back(r);
			end
		end
		alive = 0;
		for (int i = 0; i < n_peers; i++) begin
			if (peers[i].status == STAT_ALIVE) begin
				alive++;
			end
		end
		if (alive > 31) begin
			alive = 31;
		end
		foreach (step_events[k]) begin
			step_events[k].alive_count = ALIVE_OUT_W'(alive);
			step_events[k].last = (k == step_events.size() - 1);
		end
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0h, got %0h", $time, what, want, got);
		end
	endfunction

	task automatic send_request(input int gap, input logic rt, input logic [7:0] node,
		input logic [31:0] up, input logic [31:0] now);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rt;
		req_ch.node_id <= node;
		req_ch.heartbeat_uptime <= up;
		req_ch.now_ms <= now;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_TIMEOUT: limits.lost_after_ms = val;
			CFG_BCAST:   limits.broadcast_node_id = val[7:0];
			CFG_MAX_ID:  limits.max_node_id = val[7:0];
			default: ;
		endcase
	endtask

	// Drains every pending result, then lets the block run idle for a while.
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: random back-pressure, every accepted result checked in order.
	initial begin
		int gap;
		bit hurry;
		res_t want;
		hurry = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		res_ch.ready <= 1'b1;
		forever begin
			if ($urandom_range(0, 15) == 0) begin
				hurry = !hurry;
			end
			gap = hurry ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				res_ch.ready <= 1'b1;
			end
			do @(posedge clk); while (res_ch.valid !== 1'b1);
			if (pending_events.size() == 0) begin
				mismatches++;
				$display("%0t: result for peer %0h with nothing pending", $time,
					res_ch.peer_id);
			end else begin
				want = pending_events.pop_front();
				check_field("event_res", want.event_res, res_ch.event_res);
				check_field("accepted", want.accepted, res_ch.accepted);
				check_field("peer_id", want.peer_id, res_ch.peer_id);
				check_field("peer_uptime", want.peer_uptime, res_ch.peer_uptime);
				check_field("peer_heartbeats", want.peer_heartbeats, res_ch.peer_heartbeats);
				check_field("alive_count", want.alive_count, res_ch.alive_count);
				check_field("last", want.last, res_ch.last);
			end
		end
	end

	// Request side: directed table, then random phases under changing registers.
	initial begin
		int phase_items [PHASES];
		int gap;
		int pick;
		int slot;
		bit hurry;
		logic rt;
		logic [7:0] node;
		logic [31:0] up;
		logic [31:0] clock_ms;
		res_t want;

		phase_items = '{80, 80, 60, 40, 100};
		hurry = 1'b0;
		n_peers = 0;
		limits.lost_after_ms = 32'd1000;
		limits.broadcast_node_id = 8'd0;
		limits.max_node_id = 8'd127;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_TIMEOUT;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_HEARTBEAT;
		req_ch.node_id <= '0;
		req_ch.heartbeat_uptime <= '0;
		req_ch.now_ms <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[p]) begin
			send_request($urandom_range(0, 8), probes[p].rt, probes[p].node, probes[p].up,
				probes[p].now);
			track_peers(probes[p].rt, probes[p].node, probes[p].up, probes[p].now);
			if (probes[p].typed) begin
				want = '0;
				want.event_res = probes[p].ev;
				want.accepted = probes[p].acc;
				want.peer_id = probes[p].id;
				want.peer_uptime = probes[p].pup;
				want.peer_heartbeats = probes[p].phb;
				want.alive_count = probes[p].alive;
				want.last = 1'b1;
				pending_events.push_back(want);
			end else begin
				foreach (step_events[k]) pending_events.push_back(step_events[k]);
			end
		end

		clock_ms = 32'hFFFF_FF00;
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				settle();
				case (ph)
					1: begin
						write_reg(CFG_TIMEOUT, 32'd0);
						write_reg(CFG_BCAST, 32'd255);
						write_reg(CFG_MAX_ID, 32'd255);
					end
					2: begin
						write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
						write_reg(CFG_BCAST, 32'd5);
						write_reg(CFG_MAX_ID, 32'd10);
						write_reg(CFG_SPARE, $urandom);
					end
					3: begin
						write_reg(CFG_TIMEOUT, 32'd300);
						write_reg(CFG_BCAST, 32'd0);
						write_reg(CFG_MAX_ID, 32'd0);
					end
					default: begin
						write_reg(CFG_TIMEOUT, $urandom_range(200, 3000));
						write_reg(CFG_BCAST, $urandom_range(0, 255));
						write_reg(CFG_MAX_ID, 32'd127);
					end
				endcase
				cfg_we <= 1'b0;
			end
			for (int n = 0; n < phase_items[ph]; n++) begin
				rt = ($urandom_range(0, 9) < 3) ? REQ_POLL : REQ_HEARTBEAT;
				node = 8'($urandom_range(0, 255));
				up = $urandom;
				// Time mostly creeps forward and can wrap the counter; now and then it jumps to a random value.
				if ($urandom_range(0, 19) == 0) begin
					clock_ms = $urandom;
				end else begin
					clock_ms = clock_ms + $urandom_range(0, 400);
				end
				if (rt == REQ_HEARTBEAT) begin
					pick = $urandom_range(0, 19);
					if (pick < 14 && n_peers > 0) begin
						slot = $urandom_range(0, n_peers - 1);
						node = peers[slot].node;
						case ($urandom_range(0, 9))
							7: up = $urandom_range(0, peers[slot].uptime);
							8, 9: up = $urandom;
							default: up = peers[slot].uptime + $urandom_range(0, 2000);
						endcase
					end else if (pick < 16) begin
						node = limits.broadcast_node_id;
					end else if (pick < 18) begin
						node = limits.max_node_id + 8'(pick - 16);
					end
				end
				if ($urandom_range(0, 15) == 0) begin
					hurry = !hurry;
				end
				gap = hurry ? 0 : $urandom_range(0, 8);
				send_request(gap, rt, node, up, clock_ms);
				track_peers(rt, node, up, clock_ms);
				foreach (step_events[k]) pending_events.push_back(step_events[k]);
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("tb_peer_heartbeat_supervisor_top: clean");
		end else begin
			$display("tb_peer_heartbeat_supervisor_top: errors");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_peer_heartbeat_supervisor_top: errors");
		$finish;
	end

endmodule
